// ----- hdl/plc_pkg.sv -----
package plc_pkg;

    // Width of the points_in_use register and its value after reset.
    localparam int PTS_W = 5;
    localparam logic [PTS_W-1:0] PTS_RESET = 5'd2;

    // Function codes of an input word.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // Input word: one breakpoint load or one query.
    typedef struct packed {
        logic               func;
        logic [3:0]         point_index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] query_x;
    } plc_req_t;

    // Result word.
    typedef struct packed {
        logic signed [15:0] curve_y;
        logic [3:0]         segment_index;
    } plc_res_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_CHK0,
        ST_CHKN,
        ST_SCAN,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } plc_state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_QUERY,
        OP_ADDR_LAST,
        OP_FIRST,
        OP_LAST_MISS,
        OP_ADVANCE,
        OP_SEG,
        OP_CLAMP_LO,
        OP_CLAMP_HI,
        OP_MUL,
        OP_ABS,
        OP_DIV,
        OP_FIN
    } plc_op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic    ram_we;
        plc_op_t op;
    } plc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_le_rd;
        logic q_ge_rd;
        logic n_one;
        logic j_last;
        logic div_last;
    } plc_status_t;

endpackage

// ----- hdl/plc_ram.sv -----
module plc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/plc_ctrl.sv -----
module plc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 func,
    input  plc_pkg::plc_status_t status,
    output plc_pkg::plc_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    import plc_pkg::*;

    plc_state_t state_reg;
    plc_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd.ram_we = 1'b0;
        cmd.op     = OP_NONE;
        busy       = 1'b1;
        done       = 1'b0;

        unique case (state_reg) inside
            ST_IDLE, ST_DONE:
            begin
                busy       = 1'b0;
                done       = (state_reg == ST_DONE);
                state_next = ST_IDLE;
                if (start)
                begin
                    if (func == FUNC_EVAL)
                    begin
                        cmd.op     = OP_QUERY;
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        cmd.ram_we = 1'b1;
                    end
                end
            end
            ST_RD0:
            begin
                cmd.op     = OP_ADDR_LAST;
                state_next = ST_CHK0;
            end
            ST_CHK0:
            begin
                // At or below the first abscissa, or a single-point curve.
                if (status.q_le_rd || status.n_one)
                begin
                    cmd.op     = OP_CLAMP_LO;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_FIRST;
                    state_next = ST_CHKN;
                end
            end
            ST_CHKN:
            begin
                if (status.q_ge_rd)
                begin
                    cmd.op     = OP_CLAMP_HI;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_LAST_MISS;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.q_le_rd || status.j_last)
                begin
                    cmd.op     = OP_SEG;
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.op = OP_ADVANCE;
                end
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/plc_datapath.sv -----
module plc_datapath #(
    parameter int MAX_POINTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  plc_pkg::plc_req_t          request,
    input  logic                       cfg_write,
    input  logic [plc_pkg::PTS_W-1:0]  cfg_data,
    input  plc_pkg::plc_cmd_t          cmd,
    output plc_pkg::plc_status_t       status,
    output plc_pkg::plc_res_t          result
);

    import plc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [PTS_W-1:0]   pts_reg;
    logic signed [15:0] q_reg;
    logic [IDX_W-1:0]   last_reg;
    logic [IDX_W-1:0]   last_next;
    logic [IDX_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   j_reg;
    logic signed [15:0] x0_reg;
    logic signed [15:0] y0_reg;
    logic signed [15:0] x1_reg;
    logic signed [15:0] y1_reg;
    logic signed [33:0] prod_reg;
    logic signed [33:0] prod_next;
    logic [15:0]        den_reg;
    logic [15:0]        den_next;
    logic [31:0]        quo_reg;
    logic [15:0]        rem_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    plc_res_t           res_reg;

    logic               slot_ok;
    logic               ram_we;
    logic [31:0]        rd_data;
    logic signed [15:0] rd_x;
    logic signed [15:0] rd_y;
    logic signed [16:0] dy;
    logic signed [16:0] dx;
    logic signed [16:0] dxs;
    logic [33:0]        mag;
    logic [16:0]        trial;
    logic [16:0]        trial_sub;
    logic [31:0]        quo_signed;
    logic [31:0]        sum;

    // Breakpoint store: abscissa in the upper half of a word, ordinate in the lower.
    assign slot_ok = ({28'd0, request.point_index} < 32'(MAX_POINTS));
    assign ram_we  = cmd.ram_we && slot_ok;

    plc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(request.point_index)),
        .wdata ({request.point_x, request.point_y}),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign rd_x = rd_data[31:16];
    assign rd_y = rd_data[15:0];

    // Index of the last breakpoint in use, with the count clamped to the table.
    always_comb
    begin
        if (pts_reg == '0)
        begin
            last_next = '0;
        end
        else if (32'(pts_reg) > 32'(MAX_POINTS))
        begin
            last_next = IDX_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_next = IDX_W'(pts_reg - 5'd1);
        end
    end

    // Product of the ordinate step and the query offset, and the divisor.
    assign dy        = {y1_reg[15], y1_reg} - {y0_reg[15], y0_reg};
    assign dx        = {q_reg[15], q_reg} - {x0_reg[15], x0_reg};
    assign dxs       = {x1_reg[15], x1_reg} - {x0_reg[15], x0_reg};
    assign prod_next = dy * dx;
    assign den_next  = (dxs <= 17'sd0) ? 16'd1 : dxs[15:0];

    // One restoring division step.
    assign mag       = prod_reg[33] ? (-prod_reg) : prod_reg;
    assign trial     = {rem_reg, quo_reg[31]};
    assign trial_sub = trial - {1'b0, den_reg};

    // Final sum with the quotient's sign restored.
    assign quo_signed = neg_reg ? (-quo_reg) : quo_reg;
    assign sum        = {{16{y0_reg[15]}}, y0_reg} + quo_signed;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= PTS_RESET;
        end
        else if (cfg_write)
        begin
            pts_reg <= cfg_data;
        end
    end

    // Working registers, stepped by the controller.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_QUERY:
            begin
                q_reg    <= request.query_x;
                last_reg <= last_next;
                addr_reg <= '0;
            end
            OP_ADDR_LAST:
            begin
                addr_reg <= last_reg;
            end
            OP_FIRST:
            begin
                x0_reg   <= rd_x;
                y0_reg   <= rd_y;
                addr_reg <= IDX_W'(1);
            end
            OP_LAST_MISS:
            begin
                j_reg    <= IDX_W'(1);
                addr_reg <= IDX_W'(2);
            end
            OP_ADVANCE:
            begin
                x0_reg   <= rd_x;
                y0_reg   <= rd_y;
                j_reg    <= j_reg + IDX_W'(1);
                addr_reg <= addr_reg + IDX_W'(1);
            end
            OP_SEG:
            begin
                x1_reg <= rd_x;
                y1_reg <= rd_y;
            end
            OP_CLAMP_LO:
            begin
                res_reg.curve_y       <= rd_y;
                res_reg.segment_index <= 4'd0;
            end
            OP_CLAMP_HI:
            begin
                res_reg.curve_y       <= rd_y;
                res_reg.segment_index <= 4'(last_reg);
            end
            OP_MUL:
            begin
                prod_reg <= prod_next;
                den_reg  <= den_next;
            end
            OP_ABS:
            begin
                neg_reg <= prod_reg[33];
                quo_reg <= mag[31:0];
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV:
            begin
                if (!trial_sub[16])
                begin
                    rem_reg <= trial_sub[15:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            OP_FIN:
            begin
                res_reg.curve_y       <= sum[15:0];
                res_reg.segment_index <= 4'(j_reg);
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Status back to the controller.
    assign status.q_le_rd  = (q_reg <= rd_x);
    assign status.q_ge_rd  = (q_reg >= rd_x);
    assign status.n_one    = (last_reg == '0);
    assign status.j_last   = (j_reg == last_reg);
    assign status.div_last = (cnt_reg == 5'd31);

    assign result = res_reg;

endmodule

// ----- hdl/piecewise_linear_curve.sv -----
// Piecewise-linear curve lookup.
// An input word is taken at a rising edge with start high and busy low. A word with
// func low writes one breakpoint (x, y) into slot point_index; it raises no busy, gives
// no result, and the next word may follow in the next cycle. A word with func high
// evaluates the curve at query_x over the first points_in_use breakpoints.
// The result word is on result for exactly one cycle, marked by done; the receiver
// cannot hold it off, and a new word may be taken in that same cycle.
// A query that clamps at the low end answers after the states RD0 and CHK0, one that
// clamps at the high end after RD0, CHK0 and CHKN. An interpolated query walks the
// breakpoint store one entry a cycle through its single read port to find segment j,
// then passes the multiply state, the absolute-value state, a 32-step restoring
// divider and the final sum before its result is shown.
// The user must write points_in_use through cfg_write and cfg_data while the block is
// idle; the block does not enforce this. Reset returns the controller to idle and
// points_in_use to two; the breakpoint store is not cleared and must be loaded before use.
module piecewise_linear_curve #(
    parameter int MAX_POINTS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  plc_pkg::plc_req_t         request,
    output logic                      done,
    output plc_pkg::plc_res_t         result,
    input  logic                      cfg_write,
    input  logic [plc_pkg::PTS_W-1:0] cfg_data
);

    import plc_pkg::*;

    plc_cmd_t    cmd;
    plc_status_t status;

    // Sequencer.
    plc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (request.func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Store, search registers, multiplier and divider.
    plc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

`ifndef ASSERT_OFF
    // A result word is shown for one cycle only.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A taken query keeps the block busy in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.func == FUNC_EVAL)) |=> busy)
        else $error("query taken without raising busy");

    // A breakpoint load neither raises busy nor produces a result.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.func == FUNC_LOAD)) |=> (!busy && !done))
        else $error("load raised busy or produced a result");

    // A result follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a query in progress");
`endif

endmodule
